// ===== hdl/ole_pkg.sv =====
// Shared types and constants for the ordered list engine.
// Depends on nothing; the datapath, controller, core and testbench import it.
`default_nettype none

package ole_pkg;

	// default list capacity
	localparam int unsigned CAPACITY_DEF = 64;

	// fixed field widths of the request and response beats
	localparam int unsigned OP_W     = 4;
	localparam int unsigned POS_W    = 7;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned FOUND_W  = 6;
	localparam int unsigned LEN_W    = 7;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 4'd0,
		OP_INS_BACK  = 4'd1,
		OP_INS_AT    = 4'd2,
		OP_DEL_FRONT = 4'd3,
		OP_DEL_BACK  = 4'd4,
		OP_DEL_AT    = 4'd5,
		OP_READ      = 4'd6,
		OP_FIND      = 4'd7,
		OP_CLEAR     = 4'd8
	} ole_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_RANGE    = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOTFOUND = 3'd4
	} ole_status_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_LD_CNT,
		PTR_LD_POS,
		PTR_CLR,
		PTR_DEC,
		PTR_INC
	} ole_ptr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_CLR
	} ole_cnt_op_t;

	// controller to datapath
	typedef struct packed {
		logic        load;      // capture request beat
		ole_ptr_op_t ptr_op;
		ole_cnt_op_t cnt_op;
		logic        mv_up;     // read ptr-1, write it back at ptr next cycle
		logic        mv_dn;     // read ptr+1, write it back at ptr next cycle
		logic        scan_rd;   // read ptr, compare next cycle
		logic        rd_pos;    // read at the item position
		logic        wr_value;  // write item value at the item position
		logic        cap_read;  // capture read data as result
		logic        cap_found; // capture compare index as result
		logic        publish;   // load response register
		ole_status_t status;
	} ole_cmd_t;

	// datapath to controller
	typedef struct packed {
		ole_op_t op;
		logic    pos_gt_cnt;
		logic    pos_ge_cnt;
		logic    empty;
		logic    full;
		logic    ptr_gt_pos;
		logic    ptr_p1_lt_cnt;
		logic    ptr_lt_cnt;
		logic    hit;
		logic    out_free;
	} ole_sts_t;

endpackage

`default_nettype wire

// ===== hdl/ole_req_if.sv =====
// Request channel: valid/ready handshake with one list operation per beat.
// Depends on nothing.
`default_nettype none

interface ole_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         op;
	logic [6:0]         position;
	logic signed [31:0] value;

	modport source (output valid, output op, output position, output value, input ready);
	modport sink (input valid, input op, input position, input value, output ready);
endinterface

`default_nettype wire

// ===== hdl/ole_rsp_if.sv =====
// Response channel: valid/ready handshake with one result per beat.
// Depends on nothing.
`default_nettype none

interface ole_rsp_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic signed [31:0] read_value;
	logic [5:0]         found_position;
	logic [6:0]         length;

	modport source (output valid, output status, output read_value,
		output found_position, output length, input ready);
	modport sink (input valid, input status, input read_value,
		input found_position, input length, output ready);
endinterface

`default_nettype wire

// ===== hdl/ordered_list_engine_core.sv =====
// Ordered list engine top level: joins the controller and the datapath.
// Depends on ole_pkg, ole_req_if, ole_rsp_if, ole_ctrl and ole_datapath.
//
//   channel | role | beat payload
//   --------+------+------------------------------------------------
//   req     | sink | op, position, value
//   rsp     | src  | status, read_value, found_position, length
//
// One operation at a time; the memory has one read and one write port.
// Insert shifts the tail up and writes the value, delete shifts it down, find
// scans to the first match; rejected inserts and deletes, clear and unused op
// codes go to DONE. A stalled response holds the next result in DONE.
// A result waits in the response register while the next beat is taken.
// Reset empties the list at once; entry contents are not cleared.
`default_nettype none

module ordered_list_engine_core
	import ole_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	ole_req_if.sink   req,
	ole_rsp_if.source rsp
);

	ole_cmd_t cmd;
	ole_sts_t sts;

	ole_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ole_datapath #(
		.CAPACITY(CAPACITY)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.req_op             (req.op),
		.req_position       (req.position),
		.req_value          (req.value),
		.rsp_valid          (rsp.valid),
		.rsp_ready          (rsp.ready),
		.rsp_status         (rsp.status),
		.rsp_read_value     (rsp.read_value),
		.rsp_found_position (rsp.found_position),
		.rsp_length         (rsp.length)
	);

endmodule

`default_nettype wire

// ===== hdl/ole_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ole_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ole_datapath.sv =====
// Datapath: list storage, count, scan pointer, item and response registers.
// Depends on ole_pkg and ole_ram.
`default_nettype none

module ole_datapath
	import ole_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ole_cmd_t           cmd,
	output ole_sts_t                sts,
	input  wire logic [3:0]         req_op,
	input  wire logic [6:0]         req_position,
	input  wire logic signed [31:0] req_value,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output logic [2:0]              rsp_status,
	output logic signed [31:0]      rsp_read_value,
	output logic [5:0]              rsp_found_position,
	output logic [6:0]              rsp_length
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

	ole_op_t           op_q;
	logic [PW-1:0]     pos_q;
	logic [VAL_W-1:0]  val_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     ptr_q;
	logic              wpend_q;
	logic [AW-1:0]     waddr_q;
	logic              cpend_q;
	logic [AW-1:0]     cidx_q;
	logic [VAL_W-1:0]  rd_q;
	logic [AW-1:0]     fp_q;

	logic [PW-1:0]     eff_pos;
	logic [CW-1:0]     ptr_m1;
	logic [CW:0]       ptr_p1;
	logic [CW-1:0]     cnt_m1;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [VAL_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [VAL_W-1:0]  ram_rdata;
	logic [31:0]       fp_wide;
	logic [31:0]       cnt_wide;

	assign ptr_m1   = ptr_q - CW'(1);
	assign ptr_p1   = {1'b0, ptr_q} + (CW + 1)'(1);
	assign cnt_m1   = cnt_q - CW'(1);
	assign fp_wide  = 32'(fp_q);
	assign cnt_wide = 32'(cnt_q);

	// resolve the list position an operation works on
	always_comb begin
		unique case (ole_op_t'(req_op))
			OP_INS_FRONT, OP_DEL_FRONT: eff_pos = '0;
			OP_INS_BACK:                eff_pos = PW'(cnt_q);
			OP_DEL_BACK:                eff_pos = PW'(cnt_m1);
			default:                    eff_pos = PW'(req_position);
		endcase
	end

	// status flags for the controller
	assign sts.op            = op_q;
	assign sts.pos_gt_cnt    = pos_q > PW'(cnt_q);
	assign sts.pos_ge_cnt    = pos_q >= PW'(cnt_q);
	assign sts.empty         = cnt_q == '0;
	assign sts.full          = cnt_q == CW'(CAPACITY);
	assign sts.ptr_gt_pos    = PW'(ptr_q) > pos_q;
	assign sts.ptr_p1_lt_cnt = ptr_p1 < {1'b0, cnt_q};
	assign sts.ptr_lt_cnt    = ptr_q < cnt_q;
	assign sts.hit           = cpend_q && (ram_rdata == val_q);
	assign sts.out_free      = !rsp_valid || rsp_ready;

	// read port select
	always_comb begin
		ram_re = 1'b1;
		priority if (cmd.mv_up) begin
			ram_raddr = ptr_m1[AW-1:0];
		end else if (cmd.mv_dn) begin
			ram_raddr = ptr_p1[AW-1:0];
		end else if (cmd.scan_rd) begin
			ram_raddr = ptr_q[AW-1:0];
		end else if (cmd.rd_pos) begin
			ram_raddr = pos_q[AW-1:0];
		end else begin
			ram_re    = 1'b0;
			ram_raddr = ptr_q[AW-1:0];
		end
	end

	// write port: a pending shift move, else the inserted value
	assign ram_we    = wpend_q || cmd.wr_value;
	assign ram_waddr = wpend_q ? waddr_q : pos_q[AW-1:0];
	assign ram_wdata = wpend_q ? ram_rdata : val_q;

	ole_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control registers: count, pointer, pending flags, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			ptr_q     <= '0;
			wpend_q   <= 1'b0;
			cpend_q   <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			unique case (cmd.cnt_op)
				CNT_INC: cnt_q <= cnt_q + CW'(1);
				CNT_DEC: cnt_q <= cnt_m1;
				CNT_CLR: cnt_q <= '0;
				default: cnt_q <= cnt_q;
			endcase
			unique case (cmd.ptr_op)
				PTR_LD_CNT: ptr_q <= cnt_q;
				PTR_LD_POS: ptr_q <= pos_q[CW-1:0];
				PTR_CLR:    ptr_q <= '0;
				PTR_DEC:    ptr_q <= ptr_m1;
				PTR_INC:    ptr_q <= ptr_p1[CW-1:0];
				default:    ptr_q <= ptr_q;
			endcase
			wpend_q <= cmd.mv_up || cmd.mv_dn;
			cpend_q <= cmd.scan_rd;
			if (cmd.publish) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= ole_op_t'(req_op);
			pos_q <= eff_pos;
			val_q <= req_value;
			rd_q  <= '0;
			fp_q  <= '0;
		end else begin
			if (cmd.cap_read) begin
				rd_q <= ram_rdata;
			end
			if (cmd.cap_found) begin
				fp_q <= cidx_q;
			end
		end
		if (cmd.mv_up || cmd.mv_dn) begin
			waddr_q <= ptr_q[AW-1:0];
		end
		if (cmd.scan_rd) begin
			cidx_q <= ptr_q[AW-1:0];
		end
		if (cmd.publish) begin
			rsp_status         <= cmd.status;
			rsp_read_value     <= rd_q;
			rsp_found_position <= fp_wide[FOUND_W-1:0];
			rsp_length         <= cnt_wide[LEN_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ole_ctrl.sv =====
// Controller: sequences decode, shift, read and scan steps for one operation.
// Depends on ole_pkg.
`default_nettype none

module ole_ctrl
	import ole_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire ole_sts_t sts,
	output ole_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SHIFT_UP,
		S_INS_WR,
		S_SHIFT_DN,
		S_RD_CAP,
		S_SCAN,
		S_DONE
	} state_t;

	state_t      state_q, state_d;
	ole_status_t status_q, status_d;

	assign req_ready = (state_q == S_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d       = state_q;
		status_d      = status_q;
		cmd           = '0;
		cmd.ptr_op    = PTR_HOLD;
		cmd.cnt_op    = CNT_HOLD;
		cmd.status    = status_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				status_d = ST_OK;
				state_d  = S_DONE;
				unique case (sts.op)
					OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
						if (sts.pos_gt_cnt) begin
							status_d = ST_RANGE;
						end else if (sts.full) begin
							status_d = ST_FULL;
						end else begin
							cmd.ptr_op = PTR_LD_CNT;
							state_d    = S_SHIFT_UP;
						end
					end
					OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
						if (sts.empty) begin
							status_d = ST_EMPTY;
						end else if (sts.pos_ge_cnt) begin
							status_d = ST_RANGE;
						end else begin
							cmd.ptr_op = PTR_LD_POS;
							state_d    = S_SHIFT_DN;
						end
					end
					OP_READ: begin
						if (sts.pos_ge_cnt) begin
							status_d = ST_RANGE;
						end else begin
							cmd.rd_pos = 1'b1;
							state_d    = S_RD_CAP;
						end
					end
					OP_FIND: begin
						status_d   = ST_NOTFOUND;
						cmd.ptr_op = PTR_CLR;
						state_d    = S_SCAN;
					end
					OP_CLEAR: begin
						cmd.cnt_op = CNT_CLR;
					end
					default: begin
					end
				endcase
			end
			// move entries up one place, from the tail down to the position
			S_SHIFT_UP: begin
				if (sts.ptr_gt_pos) begin
					cmd.mv_up  = 1'b1;
					cmd.ptr_op = PTR_DEC;
				end else begin
					state_d = S_INS_WR;
				end
			end
			S_INS_WR: begin
				cmd.wr_value = 1'b1;
				cmd.cnt_op   = CNT_INC;
				state_d      = S_DONE;
			end
			// move entries down one place, from the position to the tail
			S_SHIFT_DN: begin
				if (sts.ptr_p1_lt_cnt) begin
					cmd.mv_dn  = 1'b1;
					cmd.ptr_op = PTR_INC;
				end else begin
					cmd.cnt_op = CNT_DEC;
					state_d    = S_DONE;
				end
			end
			S_RD_CAP: begin
				cmd.cap_read = 1'b1;
				state_d      = S_DONE;
			end
			// walk entries in order; stop at the first match
			S_SCAN: begin
				if (sts.hit) begin
					cmd.cap_found = 1'b1;
					status_d      = ST_OK;
					state_d       = S_DONE;
				end else if (sts.ptr_lt_cnt) begin
					cmd.scan_rd = 1'b1;
					cmd.ptr_op  = PTR_INC;
				end else begin
					state_d = S_DONE;
				end
			end
			// hold until the response register is free
			S_DONE: begin
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for ordered_list_engine_core: a directed table, then random
// operation sequences, checked against a behavioral list predictor or fixed rows.
// Depends on ole_pkg, ole_req_if, ole_rsp_if and the core RTL.

module tb
	import ole_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LIST_CAP       = CAPACITY_DEF;
	localparam int unsigned POS_MAX        = (1 << POS_W) - 1;
	localparam int unsigned OP_TOP         = (1 << OP_W) - 1;
	localparam int unsigned RANDOM_OPS     = 850;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 100;

	// op codes that the core ignores
	localparam logic [OP_W-1:0] OP_SPARE_LAST = 4'd15;

	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [VAL_W-1:0] VAL_ALT = 32'sh5555_5555;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic signed [VAL_W-1:0] read_value;
		logic [FOUND_W-1:0]      found_position;
		logic [LEN_W-1:0]        length;
	} list_result_t;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] val;
		logic                    typed;  // result below is fixed, not predicted
		list_result_t            want;
	} list_op_t;

	logic clk;
	logic arst_n;

	ole_req_if req_ch ();
	ole_rsp_if rsp_ch ();

	ordered_list_engine_core #(
		.CAPACITY(LIST_CAP)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predictor state: shadow copy of the list
	logic signed [VAL_W-1:0] list_vals [LIST_CAP];
	int unsigned             list_len = 0;

	list_result_t pending_results [$];
	list_op_t     cur_row = '0;
	int unsigned  beats_in = 0;
	int unsigned  results_seen = 0;
	int unsigned  ops_sent = 0;
	int unsigned  spare_sent = 0;
	int unsigned  fail_count = 0;
	int unsigned  idle_cycles = 0;
	int unsigned  burst_left = 0;
	int unsigned  status_seen [8];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// shift the tail up and drop the value in at the given slot
	function automatic ole_status_t list_insert(input int unsigned at,
			input logic signed [VAL_W-1:0] v);
		if (at > list_len)
			return ST_RANGE;
		if (list_len >= LIST_CAP)
			return ST_FULL;
		for (int i = list_len; i > at; i--)
			list_vals[i] = list_vals[i-1];
		list_vals[at] = v;
		list_len++;
		return ST_OK;
	endfunction

	// close the gap left by the removed slot
	function automatic ole_status_t list_delete(input int unsigned at);
		if (list_len == 0)
			return ST_EMPTY;
		if (at >= list_len)
			return ST_RANGE;
		for (int i = at; i + 1 < list_len; i++)
			list_vals[i] = list_vals[i+1];
		list_len--;
		return ST_OK;
	endfunction

	// apply one operation to the shadow list and return the result it gives
	function automatic list_result_t next_list_result(input logic [OP_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] val);
		ole_status_t             st;
		logic signed [VAL_W-1:0] rd;
		int unsigned             fp;
		list_result_t            r;
		st = ST_OK;
		rd = '0;
		fp = 0;
		case (op)
			OP_INS_FRONT: st = list_insert(0, val);
			OP_INS_BACK:  st = list_insert(list_len, val);
			OP_INS_AT:    st = list_insert(pos, val);
			OP_DEL_FRONT: st = list_delete(0);
			OP_DEL_BACK:  st = (list_len == 0) ? ST_EMPTY : list_delete(list_len - 1);
			OP_DEL_AT:    st = list_delete(pos);
			OP_READ: begin
				if (pos < list_len)
					rd = list_vals[pos];
				else
					st = ST_RANGE;
			end
			OP_FIND: begin
				st = ST_NOTFOUND;
				for (int i = 0; i < list_len && st != ST_OK; i++) begin
					if (list_vals[i] == val) begin
						st = ST_OK;
						fp = i;
					end
				end
			end
			OP_CLEAR: list_len = 0;
			default: ;
		endcase
		r.status         = st;
		r.read_value     = rd;
		r.found_position = fp[FOUND_W-1:0];
		r.length         = list_len[LEN_W-1:0];
		return r;
	endfunction

	function automatic list_op_t row(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] val, input logic typed,
			input logic [STATUS_W-1:0] st, input logic signed [VAL_W-1:0] rd,
			input logic [FOUND_W-1:0] fp, input logic [LEN_W-1:0] len);
		list_op_t s;
		s.op   = op;
		s.pos  = pos;
		s.val  = val;
		s.typed = typed;
		s.want = '{status: st, read_value: rd, found_position: fp, length: len};
		return s;
	endfunction

	// favor extremes and a small pool so that finds meet duplicates
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return -32'sd1;
			3: return 32'sd0;
			4, 5: return $signed($urandom_range(0, 7)) - 32'sd4;
			default: return $urandom;
		endcase
	endfunction

	// mostly a live position, now and then one at or beyond the end
	function automatic logic [POS_W-1:0] pick_pos();
		if (list_len == 0 || $urandom_range(0, 9) == 0)
			return POS_W'($urandom_range(list_len, POS_MAX));
		return POS_W'($urandom_range(0, list_len - 1));
	endfunction

	function automatic list_op_t make_insert();
		list_op_t s;
		s = '0;
		s.op  = OP_W'($urandom_range(OP_INS_FRONT, OP_INS_AT));
		s.val = pick_value();
		if (s.op != OP_INS_AT)
			s.pos = POS_W'($urandom_range(0, POS_MAX));
		else if ($urandom_range(0, 11) == 0)
			s.pos = POS_W'($urandom_range(list_len + 1, POS_MAX));
		else
			s.pos = POS_W'($urandom_range(0, list_len));
		return s;
	endfunction

	function automatic list_op_t make_delete();
		list_op_t s;
		s = '0;
		s.op  = OP_W'($urandom_range(OP_DEL_FRONT, OP_DEL_AT));
		s.pos = pick_pos();
		s.val = $urandom;
		return s;
	endfunction

	function automatic list_op_t make_probe();
		list_op_t s;
		s = '0;
		if ($urandom_range(0, 1) == 0) begin
			s.op  = OP_READ;
			s.pos = pick_pos();
			s.val = $urandom;
		end else begin
			s.op  = OP_FIND;
			s.pos = POS_W'($urandom_range(0, POS_MAX));
			if (list_len != 0 && $urandom_range(0, 2) != 0)
				s.val = list_vals[$urandom_range(0, list_len - 1)];
			else
				s.val = pick_value();
		end
		return s;
	endfunction

	function automatic list_op_t make_mixed();
		list_op_t s;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: s = make_insert();
			4, 5: s = make_delete();
			9: begin
				s = make_probe();
				if ($urandom_range(0, 3) == 0)
					s.op = OP_CLEAR;
			end
			default: s = make_probe();
		endcase
		return s;
	endfunction

	function automatic list_op_t make_noise();
		list_op_t s;
		s = '0;
		s.op  = OP_W'($urandom_range(0, OP_TOP));
		s.pos = POS_W'($urandom_range(0, POS_MAX));
		s.val = $urandom;
		return s;
	endfunction

	// present one beat; idle between bursts; return once it is taken
	task automatic send_item(input list_op_t s);
		int unsigned target;
		if (burst_left == 0) begin
			if ($urandom_range(0, 2) != 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 24);
		end
		burst_left--;
		req_ch.valid    <= 1'b1;
		req_ch.op       <= s.op;
		req_ch.position <= s.pos;
		req_ch.value    <= s.val;
		cur_row         <= s;
		if (s.op <= OP_CLEAR)
			ops_sent++;
		else
			spare_sent++;
		target = beats_in + 1;
		do @(negedge clk); while (beats_in != target);
	endtask

	// stimulus: reset, directed rows, random sequences, drain
	initial begin
		list_op_t    directed_rows [$];
		int unsigned n;
		int unsigned kind;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.op       = '0;
		req_ch.position = '0;
		req_ch.value    = '0;

		//                          op            pos      value        typed status    read     found len
		directed_rows.push_back(row(OP_READ,      7'd0,   32'sd0,  1, ST_RANGE,    32'sd0,  6'd0, 7'd0));
		directed_rows.push_back(row(OP_DEL_FRONT, 7'd0,   32'sd0,  1, ST_EMPTY,    32'sd0,  6'd0, 7'd0));
		directed_rows.push_back(row(OP_DEL_BACK,  7'd0,   32'sd0,  1, ST_EMPTY,    32'sd0,  6'd0, 7'd0));
		directed_rows.push_back(row(OP_DEL_AT,    7'd127, 32'sd0,  1, ST_EMPTY,    32'sd0,  6'd0, 7'd0));
		directed_rows.push_back(row(OP_FIND,      7'd0,   32'sd0,  1, ST_NOTFOUND, 32'sd0,  6'd0, 7'd0));
		directed_rows.push_back(row(OP_INS_AT,    7'd1,   32'sd5,  1, ST_RANGE,    32'sd0,  6'd0, 7'd0));
		directed_rows.push_back(row(OP_INS_FRONT, 7'd0,   VAL_MIN, 1, ST_OK,       32'sd0,  6'd0, 7'd1));
		directed_rows.push_back(row(OP_INS_BACK,  7'd0,   VAL_MAX, 1, ST_OK,       32'sd0,  6'd0, 7'd2));
		directed_rows.push_back(row(OP_INS_AT,    7'd1,   -32'sd1, 1, ST_OK,       32'sd0,  6'd0, 7'd3));
		directed_rows.push_back(row(OP_INS_AT,    7'd3,   VAL_ALT, 1, ST_OK,       32'sd0,  6'd0, 7'd4));
		directed_rows.push_back(row(OP_INS_AT,    7'd5,   32'sd1,  1, ST_RANGE,    32'sd0,  6'd0, 7'd4));
		directed_rows.push_back(row(OP_INS_FRONT, 7'd127, -32'sd1, 1, ST_OK,       32'sd0,  6'd0, 7'd5));
		directed_rows.push_back(row(OP_READ,      7'd0,   32'sd0,  1, ST_OK,       -32'sd1, 6'd0, 7'd5));
		directed_rows.push_back(row(OP_READ,      7'd3,   32'sd0,  1, ST_OK,       VAL_MAX, 6'd0, 7'd5));
		directed_rows.push_back(row(OP_READ,      7'd127, 32'sd0,  1, ST_RANGE,    32'sd0,  6'd0, 7'd5));
		directed_rows.push_back(row(OP_FIND,      7'd0,   -32'sd1, 1, ST_OK,       32'sd0,  6'd0, 7'd5));
		directed_rows.push_back(row(OP_FIND,      7'd0,   VAL_MAX, 1, ST_OK,       32'sd0,  6'd3, 7'd5));
		directed_rows.push_back(row(OP_FIND,      7'd0,   32'sd0,  1, ST_NOTFOUND, 32'sd0,  6'd0, 7'd5));
		directed_rows.push_back(row(OP_DEL_AT,    7'd5,   32'sd0,  1, ST_RANGE,    32'sd0,  6'd0, 7'd5));
		directed_rows.push_back(row(OP_DEL_AT,    7'd0,   32'sd0,  1, ST_OK,       32'sd0,  6'd0, 7'd4));
		directed_rows.push_back(row(OP_SPARE_LAST, 7'd127, VAL_MAX, 1, ST_OK,      32'sd0,  6'd0, 7'd4));
		directed_rows.push_back(row(OP_DEL_BACK,  7'd0,   32'sd0,  1, ST_OK,       32'sd0,  6'd0, 7'd3));
		directed_rows.push_back(row(OP_DEL_FRONT, 7'd0,   32'sd0,  0, ST_OK,       32'sd0,  6'd0, 7'd0));
		directed_rows.push_back(row(OP_INS_BACK,  7'd0,   32'sd0,  0, ST_OK,       32'sd0,  6'd0, 7'd0));
		directed_rows.push_back(row(OP_CLEAR,     7'd0,   32'sd0,  1, ST_OK,       32'sd0,  6'd0, 7'd0));

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i]);

		// random part: fill-and-drain runs, mixed traffic, raw noise
		while (ops_sent < directed_rows.size() + RANDOM_OPS) begin
			kind = $urandom_range(0, 19);
			if (kind < 5) begin
				n = LIST_CAP - list_len + $urandom_range(2, 5);
				repeat (n) send_item(make_insert());
				repeat ($urandom_range(4, 12)) send_item(make_probe());
				n = $urandom_range(list_len / 2, list_len + 3);
				repeat (n) send_item(make_delete());
			end else if (kind < 17) begin
				repeat ($urandom_range(5, 30)) send_item(make_mixed());
			end else begin
				repeat ($urandom_range(3, 10)) send_item(make_noise());
			end
		end

		// hold off until every result is back, then let stragglers show up
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d list operations and %0d ignored op codes; %0d results checked",
			ops_sent, spare_sent, results_seen);
		$display("error outcomes: %0d full, %0d out of range, %0d empty, %0d not found",
			status_seen[ST_FULL], status_seen[ST_RANGE], status_seen[ST_EMPTY],
			status_seen[ST_NOTFOUND]);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// response side: stall in a randomly chosen pattern, picked anew at random times
	initial begin
		int unsigned mode;
		int unsigned mode_left;
		int unsigned stall_left;
		int unsigned tick;
		mode         = 0;
		mode_left    = 0;
		stall_left   = 0;
		tick         = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(64, 256);
			end else begin
				mode_left--;
			end
			case (mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= 1'($urandom_range(0, 1));
				2: rsp_ch.ready <= (tick % 4 == 0);
				default: begin
					if (stall_left != 0) begin
						stall_left--;
						rsp_ch.ready <= 1'b0;
					end else begin
						if ($urandom_range(0, 5) == 0)
							stall_left = $urandom_range(1, 12);
						rsp_ch.ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// check each result beat, then predict each request beat
	always @(posedge clk) begin : check_beats
		list_result_t got;
		list_result_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				got.status         = rsp_ch.status;
				got.read_value     = rsp_ch.read_value;
				got.found_position = rsp_ch.found_position;
				got.length         = rsp_ch.length;
				if (pending_results.size() == 0) begin
					$error("result beat with nothing pending: status %0d length %0d",
						got.status, got.length);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						fail_count++;
					end
					if (got.read_value !== want.read_value) begin
						$error("read_value: expected %0d, actual %0d",
							want.read_value, got.read_value);
						fail_count++;
					end
					if (got.found_position !== want.found_position) begin
						$error("found_position: expected %0d, actual %0d",
							want.found_position, got.found_position);
						fail_count++;
					end
					if (got.length !== want.length) begin
						$error("length: expected %0d, actual %0d", want.length, got.length);
						fail_count++;
					end
				end
			end

			if (req_ch.valid && req_ch.ready) begin
				want = next_list_result(req_ch.op, req_ch.position, req_ch.value);
				status_seen[want.status]++;
				if (cur_row.typed)
					want = cur_row.want;
				pending_results.push_back(want);
				beats_in <= beats_in + 1;
			end

			// watchdog: end the run if no beat moves for too long
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

endmodule

// ===== files.f =====
hdl/ole_pkg.sv
hdl/ole_req_if.sv
hdl/ole_rsp_if.sv
hdl/ole_ram.sv
hdl/ole_datapath.sv
hdl/ole_ctrl.sv
hdl/ordered_list_engine_core.sv
dv/tb.sv
